// ===== rtl/core/gasm_pkg.sv =====
// gasm_pkg: shared types and constants of the global alignment score matrix block
// no dependencies; imported by gasm_front, gasm_back, the top level and the verification files
`default_nettype none

package gasm_pkg;

    localparam int KIND_W      = 2;
    localparam int SYM_W       = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int SCORE_OUT_W = 16;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BONUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_COST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_COST      = 2'd2;

    typedef enum logic [3:0] {
        OP_START  = 4'b0001,
        OP_APPEND = 4'b0010,
        OP_QUERY  = 4'b0100,
        OP_CLEAR  = 4'b1000
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] symbol;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] match_bonus;
        logic [CFG_W-1:0] mismatch_cost;
        logic [CFG_W-1:0] gap_cost;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/global_alignment_score_matrix_top.sv =====
// global_alignment_score_matrix_top: configuration registers, front end and row engine
// depends on gasm_pkg, gasm_front and gasm_back
`default_nettype none

// Needleman-Wunsch score matrix with a linear gap cost, one row per query
// symbol. Items pass through a two-entry command queue to a row engine.
// Append and clear items are taken by the engine and emit nothing; a start
// item is dequeued and then emits one cell per cycle; a query item is
// dequeued, then a prep state reads previous-row column 0 and forms
// -row*gap_cost, and then it emits one cell per cycle. Both emit cells
// only while the output is not stalled. The cell rate is set by the single
// read port of the previous-row memory, which delivers one entry per cycle.
// An output register holds each cell; the engine stalls while it is full
// and not taken. Configuration writes are always accepted.

module global_alignment_score_matrix_top import gasm_pkg::*;
#(
    parameter int MAX_LEN     = 32,
    parameter int SCORE_WIDTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [KIND_W-1:0]             kind,
    input  wire logic [SYM_W-1:0]              symbol,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [ROW_W-1:0]              row_index,
    output      logic [COL_W-1:0]              col_index,
    output      logic signed [SCORE_OUT_W-1:0] cell_score,
    output      logic                          row_last,
    output      logic                          overflow,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MATCH_BONUS:   cfg_next.match_bonus   = cfg_data;
                REG_MISMATCH_COST: cfg_next.mismatch_cost = cfg_data;
                REG_GAP_COST:      cfg_next.gap_cost      = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_bonus   <= CFG_W'(1);
            cfg_reg.mismatch_cost <= CFG_W'(1);
            cfg_reg.gap_cost      <= CFG_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gasm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .symbol    (symbol),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gasm_back #(
        .MAX_LEN     (MAX_LEN),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .col_index  (col_index),
        .cell_score (cell_score),
        .row_last   (row_last),
        .overflow   (overflow)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gasm_front.sv =====
// gasm_front: input acceptance, kind decode and a two-entry command queue
// depends on gasm_pkg (cmd_t, op_t, kind codes)
`default_nettype none

module gasm_front import gasm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [SYM_W-1:0]  symbol,
    output      logic              cmd_valid,
    input  wire logic              cmd_ready,
    output      cmd_t              cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       dec;

    always_comb
    begin
        dec.symbol = symbol;
        case (kind)
            KIND_START:  dec.op = OP_START;
            KIND_APPEND: dec.op = OP_APPEND;
            KIND_QUERY:  dec.op = OP_QUERY;
            KIND_CLEAR:  dec.op = OP_CLEAR;
            default:     dec.op = OP_CLEAR;
        endcase
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptrs_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers differ while empty");

    a_ptrs_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers differ while full");

endmodule

`default_nettype wire

// ===== rtl/core/gasm_back.sv =====
// gasm_back: row engine with reference and previous-row memories and output register
// depends on gasm_pkg (cmd_t, cfg_t, op_t and field widths)
`default_nettype none

module gasm_back import gasm_pkg::*;
#(
    parameter int MAX_LEN     = 32,
    parameter int SCORE_WIDTH = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cmd_valid,
    output      logic                    cmd_ready,
    input  wire cmd_t                    cmd,
    input  wire cfg_t                    cfg,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      logic [ROW_W-1:0]        row_index,
    output      logic [COL_W-1:0]        col_index,
    output      logic signed [SCORE_OUT_W-1:0] cell_score,
    output      logic                    row_last,
    output      logic                    overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int RW = $clog2(MAX_LEN + 2);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = SCORE_WIDTH;
    localparam int EW = SCORE_WIDTH + 1;
    localparam int PW = RW + CFG_W;

    localparam logic signed [SW-1:0] SMAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN   = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [EW-1:0] SMAX_E = EW'(SMAX);
    localparam logic signed [EW-1:0] SMIN_E = EW'(SMIN);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PREP = 3'b010,
        S_CELL = 3'b100
    } state_t;

    function automatic logic signed [SW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SMAX_E)
            r = SMAX;
        else if (v < SMIN_E)
            r = SMIN;
        else
            r = v[SW-1:0];
        return r;
    endfunction

    state_t               state_reg, state_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [LW-1:0]        col_reg, col_next;
    logic                 out_valid_reg, out_valid_next;

    logic [RW-1:0]        row_reg;
    logic                 ovf_reg;
    logic                 start_reg;
    logic [SYM_W-1:0]     sym_reg;
    logic signed [SW-1:0] left_reg, diag_reg, col0_reg;
    logic [RW-1:0]        row_out_reg;
    logic [LW-1:0]        col_out_reg;
    logic signed [SW-1:0] score_out_reg;
    logic                 last_out_reg, ovf_out_reg;

    logic [SYM_W-1:0]     ref_mem [MAX_LEN];
    logic signed [SW-1:0] prev_mem [MAX_LEN + 1];
    logic [SYM_W-1:0]     ref_rd;
    logic signed [SW-1:0] prev_rd;

    logic                 pop, advance, at_last;
    logic                 ref_we, prev_we, rd_en;
    logic [LW-1:0]        rd_addr;
    logic [RW-1:0]        row_new;
    logic                 ovf_new;
    logic [PW-1:0]        prod;
    logic signed [SW-1:0] col0_val;
    logic signed [EW-1:0] diag_e, up_e, left_e, best_e;
    logic signed [SW-1:0] score;
    logic [31:0]          row_w, col_w, score_w;

    assign cmd_ready = (state_reg == S_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign advance   = (state_reg == S_CELL) && (!out_valid_reg || out_ready);
    assign at_last   = (col_reg == len_reg);

    // row number of a query: held at the limit once it is reached
    assign ovf_new = (cur_reg >= LW'(MAX_LEN));
    assign row_new = ovf_new ? RW'(MAX_LEN + 1) : RW'(cur_reg) + RW'(1);

    // column 0 of a query row, registered during the prep cycle
    always_comb
    begin
        prod = PW'(row_reg) * PW'(cfg.gap_cost);
        if (33'(prod) > (33'(1) << (SW - 1)))
            col0_val = SMIN;
        else
            col0_val = -SW'(prod);
    end

    // inner cell: max of diagonal, up and left; column 0 and start-row cells take the boundary values
    always_comb
    begin
        if (ref_rd == sym_reg)
            diag_e = EW'(diag_reg) + EW'(cfg.match_bonus);
        else
            diag_e = EW'(diag_reg) - EW'(cfg.mismatch_cost);
        up_e   = EW'(prev_rd) - EW'(cfg.gap_cost);
        left_e = EW'(left_reg) - EW'(cfg.gap_cost);
        best_e = diag_e;
        if (up_e > best_e)
            best_e = up_e;
        if (left_e > best_e)
            best_e = left_e;

        if (col_reg == '0)
            score = start_reg ? '0 : col0_reg;
        else if (start_reg)
            score = sat(left_e);
        else
            score = sat(best_e);
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (cmd.op)
                        OP_START:
                        begin
                            cur_next   = '0;
                            col_next   = '0;
                            state_next = S_CELL;
                        end
                        OP_QUERY:
                        begin
                            if (!ovf_new)
                                cur_next = LW'(row_new);
                            col_next   = '0;
                            state_next = S_PREP;
                        end
                        OP_APPEND:
                        begin
                            if (len_reg < LW'(MAX_LEN))
                                len_next = len_reg + LW'(1);
                        end
                        OP_CLEAR:
                            len_next = '0;
                        default:
                            len_next = len_reg;
                    endcase
                end
            end
            S_PREP:
                state_next = S_CELL;
            S_CELL:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    col_next       = col_reg + LW'(1);
                    if (at_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            start_reg <= (cmd.op == OP_START);
            sym_reg   <= cmd.symbol;
            if (cmd.op == OP_START)
            begin
                row_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                row_reg <= row_new;
                ovf_reg <= ovf_new;
            end
        end
        if (state_reg == S_PREP)
            col0_reg <= col0_val;
        if (advance)
        begin
            left_reg      <= score;
            diag_reg      <= prev_rd;
            row_out_reg   <= row_reg;
            col_out_reg   <= col_reg;
            score_out_reg <= score;
            last_out_reg  <= at_last;
            ovf_out_reg   <= ovf_reg;
        end
    end

    // memories: one write and one registered read each
    assign ref_we  = pop && (cmd.op == OP_APPEND) && (len_reg < LW'(MAX_LEN));
    assign prev_we = advance && !ovf_reg;
    assign rd_en   = (state_reg == S_PREP) || (advance && !at_last);
    assign rd_addr = (state_reg == S_PREP) ? '0 : col_reg + LW'(1);

    always_ff @(posedge clk)
    begin
        if (ref_we)
            ref_mem[len_reg[AW-1:0]] <= cmd.symbol;
        if (rd_en)
            ref_rd <= ref_mem[col_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[col_reg] <= score;
        if (rd_en)
            prev_rd <= prev_mem[rd_addr];
    end

    assign row_w   = 32'(row_out_reg);
    assign col_w   = 32'(col_out_reg);
    assign score_w = 32'(score_out_reg);

    assign out_valid  = out_valid_reg;
    assign row_index  = row_w[ROW_W-1:0];
    assign col_index  = col_w[COL_W-1:0];
    assign cell_score = score_w[SCORE_OUT_W-1:0];
    assign row_last   = last_out_reg;
    assign overflow   = ovf_out_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CELL |-> col_reg <= len_reg)
        else $error("column beyond reference length");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        advance && at_last |=> state_reg == S_IDLE && out_valid_reg && last_out_reg)
        else $error("row did not end on last cell");

    a_no_write_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        prev_we |-> !ovf_reg)
        else $error("overflow row written to previous row");

    a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LEN) && cur_reg <= LW'(MAX_LEN))
        else $error("length or row count beyond limit");

    a_prep_to_cell: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PREP |=> state_reg == S_CELL && col_reg == '0)
        else $error("prep cycle not followed by column 0");

endmodule

`default_nettype wire

// ===== verif/gasm_row_checker.sv =====
// gasm_row_checker: watches the item, cell and register channels, predicts every cell
// and compares it field by field; depends on gasm_pkg only
`default_nettype none

module gasm_row_checker import gasm_pkg::*;
#(
    parameter int MAX_LEN     = 32,
    parameter int SCORE_WIDTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [KIND_W-1:0]             kind,
    input  wire logic [SYM_W-1:0]              symbol,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [ROW_W-1:0]              row_index,
    input  wire logic [COL_W-1:0]              col_index,
    input  wire logic signed [SCORE_OUT_W-1:0] cell_score,
    input  wire logic                          row_last,
    input  wire logic                          overflow,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_data,
    output int                                 failures,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MAX = (longint'(1) <<< (SCORE_WIDTH - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    typedef struct {
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [SCORE_OUT_W-1:0] score;
        logic                   last;
        logic                   ovf;
    } cell_t;

    logic [CFG_W-1:0] match_bonus;
    logic [CFG_W-1:0] mismatch_cost;
    logic [CFG_W-1:0] gap_cost;
    logic [SYM_W-1:0] ref_syms [MAX_LEN];
    int               ref_len;
    int               row_num;
    longint           held_row [MAX_LEN+1];
    cell_t            predicted_cells [$];

    function automatic longint saturate(longint v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    task automatic push_cell(int r, int c, longint s, bit last, bit ovf);
        cell_t cl;
        cl.row   = r[ROW_W-1:0];
        cl.col   = c[COL_W-1:0];
        cl.score = s[SCORE_OUT_W-1:0];
        cl.last  = last;
        cl.ovf   = ovf;
        predicted_cells.push_back(cl);
    endtask

    task automatic predict_row(logic [KIND_W-1:0] k, logic [SYM_W-1:0] sym);
        longint cur [MAX_LEN+1];
        longint gap;
        longint diag;
        longint up;
        longint left;
        longint best;
        bit     ovf;
        int     r;
        gap = longint'(gap_cost);
        case (k)
            KIND_APPEND:
            begin
                // appends past a full reference are dropped
                if (ref_len < MAX_LEN)
                begin
                    ref_syms[ref_len] = sym;
                    ref_len++;
                end
            end
            KIND_CLEAR:
                ref_len = 0;
            KIND_START:
            begin
                row_num = 0;
                for (int j = 0; j <= ref_len; j++)
                begin
                    held_row[j] = saturate(-longint'(j) * gap);
                    push_cell(0, j, held_row[j], j == ref_len, 1'b0);
                end
            end
            default:
            begin
                ovf = (row_num >= MAX_LEN);
                r   = ovf ? MAX_LEN + 1 : row_num + 1;
                cur[0] = saturate(-longint'(r) * gap);
                for (int j = 1; j <= ref_len; j++)
                begin
                    if (ref_syms[j-1] == sym)
                        diag = held_row[j-1] + longint'(match_bonus);
                    else
                        diag = held_row[j-1] - longint'(mismatch_cost);
                    up   = held_row[j] - gap;
                    left = cur[j-1] - gap;
                    best = diag;
                    if (up > best)
                        best = up;
                    if (left > best)
                        best = left;
                    cur[j] = saturate(best);
                end
                for (int j = 0; j <= ref_len; j++)
                    push_cell(r, j, cur[j], j == ref_len, ovf);
                // overflow rows leave the held row and the row count alone
                if (!ovf)
                begin
                    for (int j = 0; j <= ref_len; j++)
                        held_row[j] = cur[j];
                    row_num = r;
                end
            end
        endcase
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cell_t want;
        if (!rst_n)
        begin
            match_bonus   = 8'd1;
            mismatch_cost = 8'd1;
            gap_cost      = 8'd1;
            ref_len       = 0;
            row_num       = 0;
            foreach (held_row[j])
                held_row[j] = 0;
            predicted_cells.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MATCH_BONUS:   match_bonus   = cfg_data;
                    REG_MISMATCH_COST: mismatch_cost = cfg_data;
                    REG_GAP_COST:      gap_cost      = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_row(kind, symbol);
            if (out_valid && out_ready)
            begin
                if (predicted_cells.size() == 0)
                begin
                    $error("cell_score: no cell expected, got row %0d col %0d score %0d",
                           row_index, col_index, cell_score);
                    failures++;
                end
                else
                begin
                    want = predicted_cells.pop_front();
                    check_field("row_index", 32'(want.row), 32'(row_index));
                    check_field("col_index", 32'(want.col), 32'(col_index));
                    check_field("cell_score", 32'($signed(want.score)), 32'(cell_score));
                    check_field("row_last", 32'(want.last), 32'(row_last));
                    check_field("overflow", 32'(want.ovf), 32'(overflow));
                end
            end
            pending = predicted_cells.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench: drives items, register writes and cell back-pressure into the score matrix
// block and reports the verdict; depends on gasm_pkg, gasm_row_checker and the top level
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gasm_pkg::*;

    localparam int MAX_LEN = 32;
    localparam int LIMIT   = 500000;
    localparam int SETTLE  = 150;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [KIND_W-1:0]             kind;
    logic [SYM_W-1:0]              symbol;
    logic                          out_valid;
    logic                          out_ready;
    logic [ROW_W-1:0]              row_index;
    logic [COL_W-1:0]              col_index;
    logic signed [SCORE_OUT_W-1:0] cell_score;
    logic                          row_last;
    logic                          overflow;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    int failures;
    int pending;
    int cycles;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    bit quiet;

    // what the block holds, so that no query reads an unwritten column
    int sh_len;
    int sh_written;
    bit sh_started;

    global_alignment_score_matrix_top #(.MAX_LEN(MAX_LEN)) uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .symbol(symbol),
        .out_valid(out_valid), .out_ready(out_ready),
        .row_index(row_index), .col_index(col_index), .cell_score(cell_score),
        .row_last(row_last), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gasm_row_checker #(.MAX_LEN(MAX_LEN)) row_check
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .symbol(symbol),
        .out_valid(out_valid), .out_ready(out_ready),
        .row_index(row_index), .col_index(col_index), .cell_score(cell_score),
        .row_last(row_last), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // cell back-pressure in bursts of random length
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < recv_idle_pct)
            begin
                stall = $urandom_range(4, 1) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic drive_item(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
        if (!quiet && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        symbol   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic issue_item(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
        // a query that would read unwritten columns becomes a start
        if (k == KIND_QUERY && !(sh_started && sh_len <= sh_written))
            k = KIND_START;
        case (k)
            KIND_APPEND:
                if (sh_len < MAX_LEN)
                    sh_len++;
            KIND_CLEAR:
                sh_len = 0;
            KIND_START:
            begin
                sh_started = 1'b1;
                if (sh_len > sh_written)
                    sh_written = sh_len;
            end
            default: ;
        endcase
        drive_item(k, s);
    endtask

    // stop sending, let every predicted cell arrive, then let queued
    // appends and clears drain through the engine
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] bonus, logic [CFG_W-1:0] mism,
                              logic [CFG_W-1:0] gap);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_W-1:0]     val [3];
        idx = '{REG_MATCH_BONUS, REG_MISMATCH_COST, REG_GAP_COST};
        val = '{bonus, mism, gap};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // clear, load a reference, start, run queries, then a little noise
    task automatic run_segment(int alpha, bit go_long);
        int n_app;
        int n_q;
        int n_noise;
        if (go_long)
        begin
            n_app = MAX_LEN + 2;
            n_q   = MAX_LEN + 3;
        end
        else
        begin
            n_app = ($urandom_range(7) == 0) ? $urandom_range(MAX_LEN + 2, MAX_LEN - 4)
                                             : $urandom_range(6);
            n_q   = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 4, MAX_LEN + 1)
                                             : $urandom_range(8, 1);
        end
        issue_item(KIND_CLEAR, SYM_W'($urandom_range(255)));
        repeat (n_app) issue_item(KIND_APPEND, SYM_W'($urandom_range(alpha - 1)));
        issue_item(KIND_START, SYM_W'($urandom_range(255)));
        repeat (n_q) issue_item(KIND_QUERY, SYM_W'($urandom_range(alpha - 1)));
        n_noise = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        repeat (n_noise) issue_item(KIND_W'($urandom_range(3)), SYM_W'($urandom_range(255)));
    endtask

    initial
    begin
        int alpha;
        bit first;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_START;
        symbol        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MATCH_BONUS;
        cfg_data      = '0;
        quiet         = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 30;
        items_sent    = 0;
        sh_len        = 0;
        sh_written    = 0;
        sh_started    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty reference, then a short one, under the reset register values
        issue_item(KIND_START, 8'hFF);
        issue_item(KIND_QUERY, 8'h00);
        issue_item(KIND_APPEND, 8'h00);
        issue_item(KIND_APPEND, 8'hFF);
        issue_item(KIND_APPEND, 8'hA5);
        issue_item(KIND_START, 8'h00);
        issue_item(KIND_QUERY, 8'hFF);
        issue_item(KIND_QUERY, 8'h00);
        issue_item(KIND_QUERY, 8'h5A);
        // reference rebuilt after the start: rows keep reading the held row
        issue_item(KIND_CLEAR, 8'h00);
        issue_item(KIND_APPEND, 8'hFF);
        issue_item(KIND_QUERY, 8'hFF);
        issue_item(KIND_APPEND, 8'h3C);
        issue_item(KIND_APPEND, 8'hC3);
        issue_item(KIND_QUERY, 8'hC3);
        issue_item(KIND_CLEAR, 8'hFF);
        issue_item(KIND_QUERY, 8'h81);
        issue_item(KIND_START, 8'hAA);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: write_regs(8'd0, 8'd0, 8'd0);
                1: write_regs(8'd255, 8'd255, 8'd255);
                2: write_regs(8'd255, 8'd0, 8'd0);
                3: write_regs(8'd0, 8'd255, 8'd1);
                default: write_regs(CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255)),
                                    CFG_W'($urandom_range(255)));
            endcase
            send_idle_pct = (p == 2) ? 0 : 30;
            recv_idle_pct = (p == 2) ? 0 : 30;
            quiet = (p == 5);
            alpha = (p == 1 || p == 4) ? 4 : (p == 2) ? 2 : 256;
            first = 1'b1;
            // the first segment of the all-maximum phase fills the reference
            // past its end and runs the query past the last row
            while (items_sent < 20 + (p + 1) * 57)
            begin
                run_segment(alpha, first && p == 1);
                first = 1'b0;
            end
        end

        settle();
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
